@@ hdl/quicksort_engine_top_defines.svh @@
// Assertion macros for the quicksort engine checker
`ifndef QUICKSORT_ENGINE_TOP_DEFINES_SVH
`define QUICKSORT_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define QSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/qse_pkg.sv @@
// Shared constants, types and command codes of the quicksort engine
package qse_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int RANGE_W     = 2 * IDX_W;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [RANGE_W-1:0]     range_t;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
    localparam logic [OP_W-1:0] OP_INIT        = 4'd2;
    localparam logic [OP_W-1:0] OP_POP         = 4'd3;
    localparam logic [OP_W-1:0] OP_RANGE       = 4'd4;
    localparam logic [OP_W-1:0] OP_PIVOT       = 4'd5;
    localparam logic [OP_W-1:0] OP_SCAN_RD     = 4'd6;
    localparam logic [OP_W-1:0] OP_MOVE        = 4'd7;
    localparam logic [OP_W-1:0] OP_SKIP        = 4'd8;
    localparam logic [OP_W-1:0] OP_SWAP        = 4'd9;
    localparam logic [OP_W-1:0] OP_FIN_RD      = 4'd10;
    localparam logic [OP_W-1:0] OP_FIN_A       = 4'd11;
    localparam logic [OP_W-1:0] OP_FIN_B       = 4'd12;
    localparam logic [OP_W-1:0] OP_PUSH_R      = 4'd13;
    localparam logic [OP_W-1:0] OP_DRAIN_START = 4'd14;
    localparam logic [OP_W-1:0] OP_EMIT        = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic less;
        logic scan_at_hi;
        logic stack_empty;
        logic drain_last;
    } status_t;

endpackage

@@ hdl/quicksort_engine_top.sv @@
// Quicksort engine: loads a set of signed values, sorts it, streams it out in order
// Loads take 1 item per cycle while idle; after the item flagged last, a setup step, then
// per popped range a pop, range load, pivot load, final swaps and pushes, plus a read and compare
// per scanned element (and a swap if moved). Draining starts once the range stack is empty,
// then 1 sorted item per cycle; busy drops as the final item is shown. The receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the buffer count and returns to idle.
module quicksort_engine_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [qse_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                   last,
    output logic                                   strobe,
    output logic signed [qse_pkg::VALUE_WIDTH-1:0] value_res,
    output logic                                   last_res
);

    // Command and status between the sequencer and the datapath
    qse_pkg::cmd_t    cmd;
    qse_pkg::status_t status;

    // Sequencer: accepts an item when start is high in idle; an item flagged
    // last kicks off the sort, then the drain of all held items.
    qse_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath: element buffer with one write and two registered read ports,
    // range stack memory, Lomuto partition registers and the result register.
    qse_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .status    (status),
        .value_res (value_res),
        .last_res  (last_res),
        .strobe    (strobe)
    );

endmodule

@@ hdl/qse_dpath.sv @@
// Datapath: element buffer, range stack, partition registers, result registers
module qse_dpath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  qse_pkg::cmd_t             cmd,
    input  logic signed [qse_pkg::VALUE_WIDTH-1:0] value,
    output qse_pkg::status_t          status,
    output logic signed [qse_pkg::VALUE_WIDTH-1:0] value_res,
    output logic                      last_res,
    output logic                      strobe
);

    qse_pkg::value_t buf_mem [qse_pkg::DEPTH];
    qse_pkg::range_t stk_mem [qse_pkg::DEPTH];

    qse_pkg::cnt_t   cnt_reg, cnt_next;
    qse_pkg::cnt_t   sp_reg, sp_next;
    qse_pkg::cnt_t   scan_reg, scan_next;
    qse_pkg::cnt_t   store_reg, store_next;
    qse_pkg::idx_t   lo_reg, lo_next;
    qse_pkg::idx_t   hi_reg, hi_next;
    qse_pkg::value_t pivot_reg, pivot_next;
    qse_pkg::value_t rd_a_reg, rd_b_reg;
    qse_pkg::range_t stk_rd_reg;
    qse_pkg::value_t res_reg, res_next;
    logic            strobe_reg, strobe_next;
    logic            last_res_reg, last_res_next;

    logic            buf_we;
    qse_pkg::idx_t   buf_wa;
    qse_pkg::value_t buf_wd;
    logic            rda_en, rdb_en;
    qse_pkg::idx_t   rda_addr, rdb_addr;
    logic            stk_we, stk_re;
    qse_pkg::idx_t   stk_wa, stk_ra;
    qse_pkg::range_t stk_wd;

    qse_pkg::cnt_t   lo_ext, hi_ext, store_dec, store_inc, scan_inc, sp_dec;
    logic            left_ok, right_ok, stack_room;

    assign lo_ext     = qse_pkg::CNT_W'(lo_reg);
    assign hi_ext     = qse_pkg::CNT_W'(hi_reg);
    assign store_dec  = store_reg - qse_pkg::CNT_W'(1);
    assign store_inc  = store_reg + qse_pkg::CNT_W'(1);
    assign scan_inc   = scan_reg + qse_pkg::CNT_W'(1);
    assign sp_dec     = sp_reg - qse_pkg::CNT_W'(1);
    // a side range is pushed only if it holds at least two elements
    assign left_ok    = (store_reg - lo_ext) >= qse_pkg::CNT_W'(2);
    assign right_ok   = (hi_ext - store_reg) >= qse_pkg::CNT_W'(2);
    assign stack_room = sp_reg < qse_pkg::CNT_W'(qse_pkg::DEPTH);

    assign status.less        = $signed(rd_a_reg) < $signed(pivot_reg);
    assign status.scan_at_hi  = scan_reg == hi_ext;
    assign status.stack_empty = sp_reg == '0;
    assign status.drain_last  = scan_inc == cnt_reg;

    always_comb
    begin
        cnt_next      = cnt_reg;
        sp_next       = sp_reg;
        scan_next     = scan_reg;
        store_next    = store_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pivot_next    = pivot_reg;
        res_next      = res_reg;
        strobe_next   = 1'b0;
        last_res_next = 1'b0;
        buf_we        = 1'b0;
        buf_wa        = store_reg[qse_pkg::IDX_W-1:0];
        buf_wd        = rd_a_reg;
        rda_en        = 1'b0;
        rda_addr      = scan_reg[qse_pkg::IDX_W-1:0];
        rdb_en        = 1'b0;
        rdb_addr      = store_reg[qse_pkg::IDX_W-1:0];
        stk_we        = 1'b0;
        stk_wa        = sp_reg[qse_pkg::IDX_W-1:0];
        stk_wd        = {lo_reg, store_dec[qse_pkg::IDX_W-1:0]};
        stk_re        = 1'b0;
        stk_ra        = sp_dec[qse_pkg::IDX_W-1:0];
        unique case (cmd.op)
            qse_pkg::OP_LOAD:
            begin
                // drop values past a full buffer
                if (cnt_reg < qse_pkg::CNT_W'(qse_pkg::DEPTH))
                begin
                    buf_we   = 1'b1;
                    buf_wa   = cnt_reg[qse_pkg::IDX_W-1:0];
                    buf_wd   = value;
                    cnt_next = cnt_reg + qse_pkg::CNT_W'(1);
                end
            end
            qse_pkg::OP_INIT:
            begin
                sp_next = '0;
                if (cnt_reg >= qse_pkg::CNT_W'(2))
                begin
                    stk_we  = 1'b1;
                    stk_wa  = '0;
                    stk_wd  = {qse_pkg::IDX_W'(0),
                               qse_pkg::IDX_W'(cnt_reg - qse_pkg::CNT_W'(1))};
                    sp_next = qse_pkg::CNT_W'(1);
                end
            end
            qse_pkg::OP_POP:
            begin
                sp_next = sp_dec;
                stk_re  = 1'b1;
            end
            qse_pkg::OP_RANGE:
            begin
                lo_next    = stk_rd_reg[qse_pkg::RANGE_W-1:qse_pkg::IDX_W];
                hi_next    = stk_rd_reg[qse_pkg::IDX_W-1:0];
                scan_next  = qse_pkg::CNT_W'(stk_rd_reg[qse_pkg::RANGE_W-1:qse_pkg::IDX_W]);
                store_next = qse_pkg::CNT_W'(stk_rd_reg[qse_pkg::RANGE_W-1:qse_pkg::IDX_W]);
                rda_en     = 1'b1;
                rda_addr   = stk_rd_reg[qse_pkg::IDX_W-1:0];
            end
            qse_pkg::OP_PIVOT:
            begin
                pivot_next = rd_a_reg;
            end
            qse_pkg::OP_SCAN_RD:
            begin
                rda_en = 1'b1;
                rdb_en = 1'b1;
            end
            qse_pkg::OP_MOVE:
            begin
                buf_we = 1'b1;
            end
            qse_pkg::OP_SKIP:
            begin
                scan_next = scan_inc;
            end
            qse_pkg::OP_SWAP:
            begin
                buf_we     = 1'b1;
                buf_wa     = scan_reg[qse_pkg::IDX_W-1:0];
                buf_wd     = rd_b_reg;
                scan_next  = scan_inc;
                store_next = store_inc;
            end
            qse_pkg::OP_FIN_RD:
            begin
                rdb_en = 1'b1;
            end
            qse_pkg::OP_FIN_A:
            begin
                buf_we = 1'b1;
                buf_wa = hi_reg;
                buf_wd = rd_b_reg;
            end
            qse_pkg::OP_FIN_B:
            begin
                buf_we = 1'b1;
                buf_wd = pivot_reg;
                if (left_ok && stack_room)
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + qse_pkg::CNT_W'(1);
                end
            end
            qse_pkg::OP_PUSH_R:
            begin
                if (right_ok && stack_room)
                begin
                    stk_we  = 1'b1;
                    stk_wd  = {store_inc[qse_pkg::IDX_W-1:0], hi_reg};
                    sp_next = sp_reg + qse_pkg::CNT_W'(1);
                end
            end
            qse_pkg::OP_DRAIN_START:
            begin
                scan_next = '0;
                rda_en    = 1'b1;
                rda_addr  = '0;
            end
            qse_pkg::OP_EMIT:
            begin
                res_next      = rd_a_reg;
                strobe_next   = 1'b1;
                last_res_next = status.drain_last;
                rda_en        = 1'b1;
                rda_addr      = scan_inc[qse_pkg::IDX_W-1:0];
                scan_next     = scan_inc;
                if (status.drain_last)
                begin
                    cnt_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_wa] <= buf_wd;
        end
        if (rda_en)
        begin
            rd_a_reg <= buf_mem[rda_addr];
        end
        if (rdb_en)
        begin
            rd_b_reg <= buf_mem[rdb_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pivot_reg <= pivot_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            sp_reg       <= '0;
            scan_reg     <= '0;
            store_reg    <= '0;
            strobe_reg   <= 1'b0;
            last_res_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            sp_reg       <= sp_next;
            scan_reg     <= scan_next;
            store_reg    <= store_next;
            strobe_reg   <= strobe_next;
            last_res_reg <= last_res_next;
        end
    end

    assign value_res = res_reg;
    assign last_res  = last_res_reg;
    assign strobe    = strobe_reg;

endmodule

@@ hdl/qse_ctrl.sv @@
// Controller: sequences loading, partitioning, range stack handling and draining
module qse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last,
    input  qse_pkg::status_t  status,
    output qse_pkg::cmd_t     cmd,
    output logic              busy
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_LDR   = 4'd3;
    localparam logic [3:0] ST_PIV   = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_SW2   = 4'd7;
    localparam logic [3:0] ST_FIN1  = 4'd8;
    localparam logic [3:0] ST_FIN2  = 4'd9;
    localparam logic [3:0] ST_PUSHR = 4'd10;
    localparam logic [3:0] ST_DRN   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = qse_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = qse_pkg::OP_LOAD;
                    if (last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.op     = qse_pkg::OP_INIT;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (status.stack_empty)
                begin
                    cmd.op     = qse_pkg::OP_DRAIN_START;
                    state_next = ST_DRN;
                end
                else
                begin
                    cmd.op     = qse_pkg::OP_POP;
                    state_next = ST_LDR;
                end
            end
            ST_LDR:
            begin
                cmd.op     = qse_pkg::OP_RANGE;
                state_next = ST_PIV;
            end
            ST_PIV:
            begin
                cmd.op     = qse_pkg::OP_PIVOT;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                if (status.scan_at_hi)
                begin
                    cmd.op     = qse_pkg::OP_FIN_RD;
                    state_next = ST_FIN1;
                end
                else
                begin
                    cmd.op     = qse_pkg::OP_SCAN_RD;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.less)
                begin
                    cmd.op     = qse_pkg::OP_MOVE;
                    state_next = ST_SW2;
                end
                else
                begin
                    cmd.op     = qse_pkg::OP_SKIP;
                    state_next = ST_RD;
                end
            end
            ST_SW2:
            begin
                cmd.op     = qse_pkg::OP_SWAP;
                state_next = ST_RD;
            end
            ST_FIN1:
            begin
                cmd.op     = qse_pkg::OP_FIN_A;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.op     = qse_pkg::OP_FIN_B;
                state_next = ST_PUSHR;
            end
            ST_PUSHR:
            begin
                cmd.op     = qse_pkg::OP_PUSH_R;
                state_next = ST_POP;
            end
            ST_DRN:
            begin
                cmd.op = qse_pkg::OP_EMIT;
                if (status.drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

endmodule

@@ hdl/qse_checker.sv @@
// Port-level checker for the quicksort engine, bound to the top level
`include "quicksort_engine_top_defines.svh"

module qse_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic signed [qse_pkg::VALUE_WIDTH-1:0] value,
    input logic                                   last,
    input logic                                   strobe,
    input logic signed [qse_pkg::VALUE_WIDTH-1:0] value_res,
    input logic                                   last_res
);

    logic take_item;

    assign take_item = start && !busy;

    `QSE_ASSERT_NXT(a_last_starts_sort, clk, rst_n, take_item && last, busy, "sort did not start")
    `QSE_ASSERT_NXT(a_plain_load_idle, clk, rst_n, take_item && !last, !busy, "load left idle")
    `QSE_ASSERT_IMP(a_flag_on_result, clk, rst_n, last_res, strobe, "last_res without strobe")
    `QSE_ASSERT_IMP(a_mid_drain_busy, clk, rst_n, strobe && !last_res, busy, "result while idle")
    `QSE_ASSERT_NXT(a_drain_gapless, clk, rst_n, strobe && !last_res, strobe, "gap in drain")

endmodule

bind quicksort_engine_top qse_checker u_qse_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for quicksort_engine_top: loads directed and random sets, predicts each sorted stream
module testbench;

    typedef logic signed [qse_pkg::VALUE_WIDTH-1:0] sval_t;

    // One load item waiting for the driver, with the pacing it is sent under
    typedef struct {
        sval_t value;
        logic  last;
        int    idle_pct;
        bit    hold_drain;
    } load_item_t;

    // One sorted element the engine owes us
    typedef struct {
        sval_t value;
        logic  last;
    } sorted_item_t;

    localparam int ITEMS_TOTAL = 370;
    localparam int PHASE_A_END = 123;   // sender idles 24% up to here
    localparam int PHASE_B_END = 246;   // then 62%, then no random idling
    localparam int LIMIT       = 300000;
    localparam int TAIL_CYCLES = 40;
    localparam int SHOWN_MAX   = 10;

    localparam sval_t VMIN = {1'b1, {(qse_pkg::VALUE_WIDTH-1){1'b0}}};
    localparam sval_t VMAX = {1'b0, {(qse_pkg::VALUE_WIDTH-1){1'b1}}};

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    sval_t value = '0;
    logic  last  = 1'b0;
    logic  busy;
    logic  strobe;
    sval_t value_res;
    logic  last_res;

    // Predictor state: our own copy of the element buffer and its fill count
    sval_t        held_buf [qse_pkg::DEPTH];
    int           held_count = 0;
    sorted_item_t sorted_due[$];
    load_item_t   pending_items[$];

    int queued      = 0;
    int err_count   = 0;
    int cycle_count = 0;
    bit took_item   = 1'b0;

    quicksort_engine_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .last      (last),
        .strobe    (strobe),
        .value_res (value_res),
        .last_res  (last_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sort the held elements in place: Lomuto partition, last element of each
    // range as pivot, pending ranges on a bounded stack (right half popped first).
    task automatic lomuto_sort_held();
        int    lo_stack[$];
        int    hi_stack[$];
        int    lo;
        int    hi;
        int    store;
        sval_t pivot;
        sval_t tmp;
        if (held_count >= 2)
        begin
            lo_stack.push_back(0);
            hi_stack.push_back(held_count - 1);
        end
        while (lo_stack.size() > 0)
        begin
            lo    = lo_stack.pop_back();
            hi    = hi_stack.pop_back();
            pivot = held_buf[hi];
            store = lo;
            for (int scan = lo; scan < hi; scan++)
            begin
                // Signed compare: both operands are sval_t
                if (held_buf[scan] < pivot)
                begin
                    tmp             = held_buf[store];
                    held_buf[store] = held_buf[scan];
                    held_buf[scan]  = tmp;
                    store++;
                end
            end
            tmp             = held_buf[store];
            held_buf[store] = held_buf[hi];
            held_buf[hi]    = tmp;
            // Push left part, then right part; drop empty or single ranges
            if (store > lo + 1 && lo_stack.size() < qse_pkg::DEPTH)
            begin
                lo_stack.push_back(lo);
                hi_stack.push_back(store - 1);
            end
            if (store + 1 < hi && lo_stack.size() < qse_pkg::DEPTH)
            begin
                lo_stack.push_back(store + 1);
                hi_stack.push_back(hi);
            end
        end
    endtask

    // Absorb one accepted load item; on a last flag, queue up the whole sorted set.
    // Past DEPTH elements the value is dropped, but a last flag still closes the set.
    task automatic collect_element(sval_t v, logic l);
        sorted_item_t r;
        if (held_count < qse_pkg::DEPTH)
        begin
            held_buf[held_count] = v;
            held_count++;
        end
        if (l)
        begin
            lomuto_sort_held();
            for (int k = 0; k < held_count; k++)
            begin
                r.value = held_buf[k];
                r.last  = (k == held_count - 1);
                sorted_due.push_back(r);
            end
            held_count = 0;
        end
    endtask

    // Append one load item; its idle rate follows from where it falls in the run
    task automatic queue_item(sval_t v, logic l, bit hold = 1'b0);
        load_item_t it;
        it.value      = v;
        it.last       = l;
        it.hold_drain = hold;
        it.idle_pct   = (queued < PHASE_A_END) ? 24 : (queued < PHASE_B_END) ? 62 : 0;
        pending_items.push_back(it);
        queued++;
    endtask

    // Mix of narrow values (lots of duplicates), near-extremes and full-range noise
    function automatic sval_t pick_value();
        unique case ($urandom_range(3))
            0:       return $signed($urandom_range(16)) - 8;
            1:       return $urandom_range(1) ? VMIN + $urandom_range(3)
                                              : VMAX - $urandom_range(3);
            default: return $urandom();
        endcase
    endfunction

    // Driver: advance at the falling edge once the presented item was taken.
    // Hold start, value and last steady while the engine is busy and an item is presented.
    always @(negedge clk)
    begin
        load_item_t nxt;
        if (rst_n && (!start || took_item))
        begin
            // Idle when nothing is left, when the next item must wait for the
            // previous set to drain completely, or on a random gap.
            if (pending_items.size() == 0 ||
                (pending_items[0].hold_drain && sorted_due.size() != 0) ||
                $urandom_range(99) < pending_items[0].idle_pct)
            begin
                start <= 1'b0;
                value <= $urandom();
                last  <= 1'($urandom_range(1));
            end
            else
            begin
                nxt    = pending_items.pop_front();
                start <= 1'b1;
                value <= nxt.value;
                last  <= nxt.last;
            end
        end
    end

    // Monitor: sample at the rising edge, check results first, then predict
    // from the item accepted at this edge (start high, busy low).
    always @(posedge clk)
    begin
        sorted_item_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (sorted_due.size() == 0)
                begin
                    err_count++;
                    if (err_count <= SHOWN_MAX)
                        $display("unexpected result: value %0d last %0b", value_res, last_res);
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (want.value !== value_res || want.last !== last_res)
                    begin
                        err_count++;
                        if (err_count <= SHOWN_MAX)
                            $display({"result differs: expected value %0d last %0b, ",
                                      "got value %0d last %0b"},
                                     want.value, want.last, value_res, last_res);
                    end
                end
            end
            took_item <= start && !busy;
            if (start && !busy)
                collect_element(value, last);
        end
    end

    // Watchdog: a hung engine or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("quicksort_engine_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        int set_idx;
        int set_len;

        // Directed sets: lone extremes, full-range mix, duplicates, bit patterns,
        // strictly descending input.
        queue_item(VMIN, 1'b1);
        queue_item(VMAX, 1'b1);
        queue_item(VMAX, 1'b0);
        queue_item(VMIN, 1'b0);
        queue_item(0, 1'b0);
        queue_item(-1, 1'b0);
        queue_item(1, 1'b1);
        repeat (3) queue_item(7, 1'b0);
        queue_item(7, 1'b1);
        queue_item(sval_t'(32'h5555_5555), 1'b0);
        queue_item(sval_t'(32'hAAAA_AAAA), 1'b0);
        queue_item(VMIN + 1, 1'b0);
        queue_item(VMAX - 1, 1'b1);
        queue_item(4, 1'b0);
        queue_item(3, 1'b0);
        queue_item(2, 1'b0);
        queue_item(1, 1'b1);

        // Random sets, mostly short. One set fills the buffer exactly; another
        // overruns it so the extra values drop and the dropped final one closes it.
        // Now and then the first item of a set waits for the previous drain.
        set_idx = 0;
        while (queued < ITEMS_TOTAL)
        begin
            unique case (set_idx)
                3:       set_len = qse_pkg::DEPTH;
                9:       set_len = qse_pkg::DEPTH + 3;
                default: set_len = $urandom_range(12, 1);
            endcase
            for (int k = 0; k < set_len; k++)
                queue_item(pick_value(), k == set_len - 1, k == 0 && set_idx % 6 == 0);
            set_idx++;
        end

        // Hold reset for a while, then drop it on a falling edge
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item is taken and every sorted element is back
        while (pending_items.size() != 0 || start || sorted_due.size() != 0)
            @(negedge clk);
        // Watch a little longer for stray strobes
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_count == 0 && sorted_due.size() == 0)
            $display("quicksort_engine_top: match");
        else
            $display("quicksort_engine_top: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/qse_pkg.sv
hdl/qse_dpath.sv
hdl/qse_ctrl.sv
hdl/quicksort_engine_top.sv
hdl/qse_checker.sv
dv/testbench.sv
